// File: hw/rtl/ists_pkg.sv
// Shared types, constants and the sine table for the tone sequencer.
`default_nettype none
package ists_pkg;

  localparam int TABLE_POINTS   = 36;
  localparam int SEQUENCE_STEPS = 12;
  localparam int TABLE_ENTRIES  = 37;

  localparam int INC_W    = 12;
  localparam int SAMPLE_W = 10;
  localparam int FRAC_W   = 8;
  localparam int PT_W     = $clog2(TABLE_POINTS + 1);
  localparam int PH_W     = PT_W + FRAC_W;
  localparam int PERIOD   = TABLE_POINTS * 256;
  localparam int SUM_W    = ((PH_W > INC_W) ? PH_W : INC_W) + 1;
  localparam int STEP_W   = (SEQUENCE_STEPS > 1) ? $clog2(SEQUENCE_STEPS) : 1;
  localparam int IDX_W    = 4;

  // worst-case number of subtractions to bring an increment below one period
  localparam int MOD_STEPS = ((1 << INC_W) - 1) / PERIOD;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    op_t                kind;
    logic [STEP_W-1:0]  idx;
    logic [INC_W-1:0]   incr;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One period of the sine, offset to unsigned; entries past the end read zero.
  function automatic logic [SAMPLE_W-1:0] sine_at(input logic [PT_W-1:0] i);
    int n;
    logic [SAMPLE_W-1:0] s;
    n = int'(i);
    case (n)
      0:  s = 10'd511;  1:  s = 10'd599;  2:  s = 10'd685;  3:  s = 10'd766;
      4:  s = 10'd839;  5:  s = 10'd902;  6:  s = 10'd953;  7:  s = 10'd991;
      8:  s = 10'd1014; 9:  s = 10'd1022; 10: s = 10'd1014; 11: s = 10'd991;
      12: s = 10'd953;  13: s = 10'd902;  14: s = 10'd839;  15: s = 10'd766;
      16: s = 10'd685;  17: s = 10'd599;  18: s = 10'd511;  19: s = 10'd422;
      20: s = 10'd336;  21: s = 10'd255;  22: s = 10'd182;  23: s = 10'd119;
      24: s = 10'd68;   25: s = 10'd30;   26: s = 10'd7;    27: s = 10'd0;
      28: s = 10'd7;    29: s = 10'd30;   30: s = 10'd68;   31: s = 10'd119;
      32: s = 10'd182;  33: s = 10'd255;  34: s = 10'd336;  35: s = 10'd422;
      36: s = 10'd511;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ists_front.sv
// Front end: decodes requests, drops out-of-range loads, folds increments.
`default_nettype none
module ists_front
  import ists_pkg::*;
(
  input  wire logic                 in_valid,
  input  wire logic                 opcode,
  input  wire logic [IDX_W-1:0]     step_index,
  input  wire logic [INC_W-1:0]     step_increment,
  input  wire q_status_t            q_status,
  output logic                      in_ready,
  output logic                      push,
  output q_entry_t                  entry
);

  logic             keep;
  logic [INC_W-1:0] incr_mod;

  // reduce the increment below one period so the back end needs one subtract
  always_comb begin
    incr_mod = step_increment;
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (int'(incr_mod) >= PERIOD) begin
        incr_mod = incr_mod - INC_W'(PERIOD);
      end
    end
  end

  always_comb begin
    unique case (op_t'(opcode))
      OP_TICK: keep = 1'b1;
      OP_LOAD: keep = (int'(step_index) < SEQUENCE_STEPS);
      default: keep = 1'b0;
    endcase
  end

  assign in_ready   = !q_status.full;
  assign push       = in_valid && in_ready && keep;
  assign entry.kind = op_t'(opcode);
  assign entry.idx  = STEP_W'(step_index);
  assign entry.incr = incr_mod;

endmodule
`default_nettype wire

// File: hw/rtl/ists_queue.sv
// Short FIFO between the front and back ends.
`default_nettype none
module ists_queue
  import ists_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire q_entry_t  push_entry,
  input  wire logic      pop,
  output q_entry_t       head,
  output q_status_t      status
);

  q_entry_t           slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + (QPTR_W+1)'(1);
      else if (pop && !push) count <= count - (QPTR_W+1)'(1);
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign status.empty = (count == '0);

endmodule
`default_nettype wire

// File: hw/rtl/ists_back.sv
// Back end: step store, phase accumulator, interpolation pipeline, output register.
`default_nettype none
module ists_back
  import ists_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire q_entry_t             head,
  input  wire q_status_t            q_status,
  output logic                      pop,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [SAMPLE_W-1:0]       dac_code
);

  logic [INC_W-1:0]  inc_store [SEQUENCE_STEPS];
  logic [STEP_W-1:0] step_pos;
  logic [PH_W-1:0]   phase;
  logic              primed;

  logic              adv;
  logic              tick;
  logic [INC_W-1:0]  cur_inc;
  logic [SUM_W-1:0]  ph_sum;
  logic [PH_W-1:0]   phase_next;

  // stage 1: phase before this tick
  logic              s1_valid;
  logic              s1_first;
  logic [PH_W-1:0]   s1_phase;
  // stage 2: table points and weights
  logic              s2_valid;
  logic              s2_first;
  logic [SAMPLE_W-1:0] s2_lo;
  logic [SAMPLE_W-1:0] s2_hi;
  logic [FRAC_W:0]   s2_wlo;
  logic [FRAC_W-1:0] s2_whi;
  // stage 3: products
  logic              s3_valid;
  logic              s3_first;
  logic [SAMPLE_W+FRAC_W:0]   s3_plo;
  logic [SAMPLE_W+FRAC_W-1:0] s3_phi;

  logic [PT_W-1:0]   pt_lo;
  logic [PT_W-1:0]   pt_hi;
  logic [SAMPLE_W+FRAC_W:0] interp;

  assign adv  = !out_valid || out_ready;
  assign pop  = adv && !q_status.empty;
  assign tick = pop && (head.kind == OP_TICK);

  assign cur_inc = inc_store[step_pos];
  assign ph_sum  = SUM_W'(phase) + SUM_W'(cur_inc);

  always_comb begin
    if (ph_sum >= SUM_W'(PERIOD)) begin
      phase_next = PH_W'(ph_sum - SUM_W'(PERIOD));
    end else begin
      phase_next = PH_W'(ph_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEQUENCE_STEPS; i++) begin
        inc_store[i] <= '0;
      end
      step_pos <= '0;
      phase    <= '0;
      primed   <= 1'b0;
    end else if (pop) begin
      unique case (head.kind)
        OP_LOAD: begin
          inc_store[head.idx] <= head.incr;
        end
        OP_TICK: begin
          phase  <= phase_next;
          primed <= 1'b1;
          if (step_pos < STEP_W'(SEQUENCE_STEPS - 1)) begin
            step_pos <= step_pos + STEP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign pt_lo = s1_phase[PH_W-1:FRAC_W];
  assign pt_hi = pt_lo + PT_W'(1);
  assign interp = s3_plo + (SAMPLE_W+FRAC_W+1)'(s3_phi);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= tick;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= !primed;
      s1_phase <= phase;

      s2_first <= s1_first;
      s2_lo    <= sine_at(pt_lo);
      s2_hi    <= sine_at(pt_hi);
      s2_wlo   <= (FRAC_W+1)'(256) - (FRAC_W+1)'(s1_phase[FRAC_W-1:0]);
      s2_whi   <= s1_phase[FRAC_W-1:0];

      s3_first <= s2_first;
      s3_plo   <= (SAMPLE_W+FRAC_W+1)'(s2_lo) * (SAMPLE_W+FRAC_W+1)'(s2_wlo);
      s3_phi   <= (SAMPLE_W+FRAC_W)'(s2_hi) * (SAMPLE_W+FRAC_W)'(s2_whi);

      // the sum is the interpolated sample scaled by 256; its code drops eight bits
      dac_code <= s3_first ? '0 : interp[SAMPLE_W+FRAC_W-1:FRAC_W];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/interpolated_sine_tone_sequencer.sv
// Top level of the interpolated sine tone sequencer.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    opcode, step_index, step_increment
//  out      source     out_valid/out_ready  dac_code
//
// One request per cycle is taken while the four-entry queue has room.
// A tick's dac_code passes the interpolation pipeline and the output register; the phase
// accumulator steps as ticks leave the queue; unstalled ticks run back to back.
// Loads write the step store as they leave the queue and give no result.
// Synchronous reset clears the step store (in flip-flops), phase and step.
// A stalled output freezes the whole back end; the queue then fills and
// in_ready drops.
`default_nettype none
module interpolated_sine_tone_sequencer
  import ists_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  opcode,
  input  wire logic [IDX_W-1:0]      step_index,
  input  wire logic [INC_W-1:0]      step_increment,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SAMPLE_W-1:0]        dac_code
);

  logic      push;
  logic      pop;
  q_entry_t  push_entry;
  q_entry_t  head;
  q_status_t q_status;

  // decode and filter incoming requests
  ists_front u_front (
    .in_valid       (in_valid),
    .opcode         (opcode),
    .step_index     (step_index),
    .step_increment (step_increment),
    .q_status       (q_status),
    .in_ready       (in_ready),
    .push           (push),
    .entry          (push_entry)
  );

  // decouples the front from output stalls
  ists_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // synthesis pipeline and output register
  ists_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .dac_code  (dac_code)
  );

`ifndef SYNTHESIS
  a_q_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("push into full queue");

  a_dac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dac_code <= 10'd1022))
    else $error("dac_code out of range");
`endif

endmodule
`default_nettype wire
